[sv/clel_pkg.sv]
// ----------------------------------------------------------------------------
// clel_pkg
// Types, constants and helpers shared by the circular list engine.
// ----------------------------------------------------------------------------
package clel_pkg;

    // Store size and value width
    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W    = 9;
    localparam int SKIP_W     = 16;
    localparam int SKIP_CNT_W = $clog2(SKIP_W);

    // Command codes
    localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
    localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
    localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
    localparam logic [3:0] MODE_POP_BACK   = 4'd3;
    localparam logic [3:0] MODE_FIND       = 4'd4;
    localparam logic [3:0] MODE_INS_BEFORE = 4'd5;
    localparam logic [3:0] MODE_INS_AFTER  = 4'd6;
    localparam logic [3:0] MODE_REMOVE     = 4'd7;
    localparam logic [3:0] MODE_ELIMINATE  = 4'd8;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] search_key;
        logic signed [31:0] new_value;
        logic [15:0]        skip_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         entry_count;
        logic signed [31:0] head_value;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_POPB,
        ST_FIND,
        ST_ALLOC,
        ST_ALLOC_W,
        ST_LINK1,
        ST_LINK2,
        ST_UNL_RD,
        ST_UNL_W1,
        ST_UNL_W2,
        ST_ELIM_CHK,
        ST_ELIM_DIV,
        ST_ELIM_WALK,
        ST_ELIM_STEP,
        ST_FIN,
        ST_FIN2
    } state_t;

    // Port word to stored value: sign extend, then keep VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] to_val(input logic [31:0] x);
        logic [63:0] w;
        w = {{32{x[31]}}, x};
        return w[VALUE_BITS-1:0];
    endfunction

    // Stored value to port word: sign extend from VALUE_BITS, keep 32
    function automatic logic [31:0] from_val(input logic [VALUE_BITS-1:0] v);
        logic [127:0] w;
        w = {{(128 - VALUE_BITS){v[VALUE_BITS-1]}}, v};
        return w[31:0];
    endfunction

endpackage

[sv/circular_list_engine.sv]
// ----------------------------------------------------------------------------
// circular_list_engine
// Circular doubly linked list in link memories with a free list and elimination.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: one command per transfer (cmd_valid high, cmd_stall low).
//   rsp channel: one result per command with status, count and head value.
//   Commands run one at a time; cmd_stall is high while a command executes.
//   Find, insert and remove walk the list one node per cycle from the head.
//   Eliminate: per removed node, start the bit-serial remainder of the skip
//   count, wait until it is done, step over that many nodes, then unlink.
//   The link walk is set by the single read port of the next-link memory.
//   Reset: a clearing pass chains the free list in the next-link memory;
//   cmd_stall stays high until it is done.
//   The result sits in an output register; a new command is taken while it
//   waits. A stalled receiver holds the next result in its final state.
// ----------------------------------------------------------------------------
module circular_list_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  clel_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output clel_pkg::rsp_t  rsp
);

    localparam int IW = clel_pkg::IDX_W;
    localparam int CW = clel_pkg::CNT_W;
    localparam int VW = clel_pkg::VALUE_BITS;

    clel_pkg::state_t  state_reg, state_next;
    clel_pkg::cmd_t    cmd_reg, cmd_next;
    clel_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [IW-1:0]     init_reg, init_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     free_reg, free_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     p_reg, p_next;
    logic [IW-1:0]     new_reg, new_next;
    logic [CW-1:0]     walk_reg, walk_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [1:0]        status_reg, status_next;

    // memory ports
    logic              v_we, n_we, p_we;
    logic [IW-1:0]     v_wa, v_ra, n_wa, n_ra, p_wa, p_ra;
    logic [VW-1:0]     v_wd, v_rd;
    logic [IW-1:0]     n_wd, n_rd, p_wd, p_rd;

    logic              rem_start, rem_done;
    logic [CW-1:0]     rem_val;
    logic              cmd_xfer;
    logic              full;

    clel_ram #(.WIDTH(VW), .DEPTH(clel_pkg::CAPACITY)) u_val_ram (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );

    clel_ram #(.WIDTH(IW), .DEPTH(clel_pkg::CAPACITY)) u_next_ram (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
    );

    clel_ram #(.WIDTH(IW), .DEPTH(clel_pkg::CAPACITY)) u_prev_ram (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );

    clel_rem u_rem (
        .clk(clk), .rst_n(rst_n), .start(rem_start),
        .dividend(cmd_reg.skip_count), .divisor(count_reg),
        .done(rem_done), .remainder(rem_val)
    );

    assign cmd_stall = (state_reg != clel_pkg::ST_IDLE);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign full      = (count_reg == CW'(clel_pkg::CAPACITY));

    // sequencer: next state, memory accesses and list registers
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        init_next      = init_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        p_next         = p_reg;
        new_next       = new_reg;
        walk_next      = walk_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        v_we = 1'b0; v_wa = new_reg; v_wd = '0; v_ra = head_reg;
        n_we = 1'b0; n_wa = '0;      n_wd = '0; n_ra = cur_reg;
        p_we = 1'b0; p_wa = '0;      p_wd = '0; p_ra = head_reg;
        rem_start = 1'b0;

        // result drains independently of the sequencer
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            clel_pkg::ST_INIT:
            begin
                n_we = 1'b1;
                n_wa = init_reg;
                if (init_reg == IW'(clel_pkg::CAPACITY - 1))
                begin
                    n_wd       = '0;
                    state_next = clel_pkg::ST_IDLE;
                end
                else
                begin
                    n_wd = init_reg + 1'b1;
                end
                init_next = init_reg + 1'b1;
            end

            clel_pkg::ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    cmd_next    = cmd;
                    status_next = clel_pkg::STAT_OK;
                    state_next  = clel_pkg::ST_DECODE;
                end
            end

            clel_pkg::ST_DECODE:
            begin
                cur_next = head_reg;
                if (cmd_reg.mode == clel_pkg::MODE_PUSH_FRONT ||
                    cmd_reg.mode == clel_pkg::MODE_PUSH_BACK)
                begin
                    if (full)
                    begin
                        status_next = clel_pkg::STAT_FULL;
                        state_next  = clel_pkg::ST_FIN;
                    end
                    else
                    begin
                        pos_next   = head_reg;
                        state_next = clel_pkg::ST_ALLOC;
                    end
                end
                else if (cmd_reg.mode > clel_pkg::MODE_ELIMINATE)
                begin
                    state_next = clel_pkg::ST_FIN;
                end
                else if (count_reg == '0)
                begin
                    status_next = clel_pkg::STAT_EMPTY;
                    state_next  = clel_pkg::ST_FIN;
                end
                else
                begin
                    case (cmd_reg.mode) inside
                        clel_pkg::MODE_POP_FRONT:
                        begin
                            idx_next   = head_reg;
                            state_next = clel_pkg::ST_UNL_RD;
                        end
                        clel_pkg::MODE_POP_BACK:
                        begin
                            p_ra       = head_reg;
                            state_next = clel_pkg::ST_POPB;
                        end
                        clel_pkg::MODE_FIND, clel_pkg::MODE_INS_BEFORE,
                        clel_pkg::MODE_INS_AFTER, clel_pkg::MODE_REMOVE:
                        begin
                            v_ra       = head_reg;
                            n_ra       = head_reg;
                            walk_next  = '0;
                            state_next = clel_pkg::ST_FIND;
                        end
                        default:
                        begin
                            state_next = clel_pkg::ST_ELIM_CHK;
                        end
                    endcase
                end
            end

            clel_pkg::ST_POPB:
            begin
                idx_next   = p_rd;
                state_next = clel_pkg::ST_UNL_RD;
            end

            // one node per cycle: compare and fetch the successor
            clel_pkg::ST_FIND:
            begin
                if (v_rd == clel_pkg::to_val(cmd_reg.search_key))
                begin
                    case (cmd_reg.mode) inside
                        clel_pkg::MODE_FIND:
                        begin
                            state_next = clel_pkg::ST_FIN;
                        end
                        clel_pkg::MODE_INS_BEFORE, clel_pkg::MODE_INS_AFTER:
                        begin
                            if (full)
                            begin
                                status_next = clel_pkg::STAT_FULL;
                                state_next  = clel_pkg::ST_FIN;
                            end
                            else
                            begin
                                pos_next   = (cmd_reg.mode == clel_pkg::MODE_INS_AFTER)
                                             ? n_rd : cur_reg;
                                state_next = clel_pkg::ST_ALLOC;
                            end
                        end
                        default:
                        begin
                            idx_next   = cur_reg;
                            state_next = clel_pkg::ST_UNL_RD;
                        end
                    endcase
                end
                else if ((walk_reg + CW'(1)) == count_reg)
                begin
                    status_next = clel_pkg::STAT_NOT_FOUND;
                    state_next  = clel_pkg::ST_FIN;
                end
                else
                begin
                    cur_next  = n_rd;
                    walk_next = walk_reg + CW'(1);
                    v_ra      = n_rd;
                    n_ra      = n_rd;
                end
            end

            // take a node off the free list
            clel_pkg::ST_ALLOC:
            begin
                new_next   = free_reg;
                n_ra       = free_reg;
                p_ra       = pos_reg;
                state_next = clel_pkg::ST_ALLOC_W;
            end

            clel_pkg::ST_ALLOC_W:
            begin
                free_next  = n_rd;
                p_next     = p_rd;
                v_we       = 1'b1;
                v_wa       = new_reg;
                v_wd       = (cmd_reg.mode <= clel_pkg::MODE_PUSH_BACK)
                             ? clel_pkg::to_val(cmd_reg.search_key)
                             : clel_pkg::to_val(cmd_reg.new_value);
                state_next = clel_pkg::ST_LINK1;
            end

            clel_pkg::ST_LINK1:
            begin
                n_we = 1'b1;
                n_wa = new_reg;
                p_we = 1'b1;
                p_wa = new_reg;
                if (count_reg == '0)
                begin
                    // first node links to itself
                    n_wd       = new_reg;
                    p_wd       = new_reg;
                    head_next  = new_reg;
                    count_next = count_reg + CW'(1);
                    state_next = clel_pkg::ST_FIN;
                end
                else
                begin
                    n_wd       = pos_reg;
                    p_wd       = p_reg;
                    state_next = clel_pkg::ST_LINK2;
                end
            end

            clel_pkg::ST_LINK2:
            begin
                n_we       = 1'b1;
                n_wa       = p_reg;
                n_wd       = new_reg;
                p_we       = 1'b1;
                p_wa       = pos_reg;
                p_wd       = new_reg;
                count_next = count_reg + CW'(1);
                if (cmd_reg.mode == clel_pkg::MODE_PUSH_FRONT ||
                    (cmd_reg.mode == clel_pkg::MODE_INS_BEFORE && pos_reg == head_reg))
                begin
                    head_next = new_reg;
                end
                state_next = clel_pkg::ST_FIN;
            end

            // unlink idx and return it to the free list
            clel_pkg::ST_UNL_RD:
            begin
                n_ra       = idx_reg;
                p_ra       = idx_reg;
                state_next = clel_pkg::ST_UNL_W1;
            end

            clel_pkg::ST_UNL_W1:
            begin
                if (count_reg > CW'(1))
                begin
                    n_we     = 1'b1;
                    n_wa     = p_rd;
                    n_wd     = n_rd;
                    p_we     = 1'b1;
                    p_wa     = n_rd;
                    p_wd     = p_rd;
                    cur_next = n_rd;
                    if (idx_reg == head_reg)
                    begin
                        head_next = n_rd;
                    end
                end
                state_next = clel_pkg::ST_UNL_W2;
            end

            clel_pkg::ST_UNL_W2:
            begin
                n_we       = 1'b1;
                n_wa       = idx_reg;
                n_wd       = free_reg;
                free_next  = idx_reg;
                count_next = count_reg - CW'(1);
                state_next = (cmd_reg.mode == clel_pkg::MODE_ELIMINATE)
                             ? clel_pkg::ST_ELIM_CHK : clel_pkg::ST_FIN;
            end

            // elimination rounds
            clel_pkg::ST_ELIM_CHK:
            begin
                if (count_reg <= CW'(1))
                begin
                    head_next  = cur_reg;
                    state_next = clel_pkg::ST_FIN;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = clel_pkg::ST_ELIM_DIV;
                end
            end

            clel_pkg::ST_ELIM_DIV:
            begin
                if (rem_done)
                begin
                    steps_next = rem_val;
                    state_next = clel_pkg::ST_ELIM_WALK;
                end
            end

            clel_pkg::ST_ELIM_WALK:
            begin
                if (steps_reg == '0)
                begin
                    idx_next   = cur_reg;
                    state_next = clel_pkg::ST_UNL_RD;
                end
                else
                begin
                    n_ra       = cur_reg;
                    state_next = clel_pkg::ST_ELIM_STEP;
                end
            end

            clel_pkg::ST_ELIM_STEP:
            begin
                cur_next   = n_rd;
                steps_next = steps_reg - CW'(1);
                state_next = clel_pkg::ST_ELIM_WALK;
            end

            // fetch head value, then load the result register
            clel_pkg::ST_FIN:
            begin
                v_ra       = head_reg;
                state_next = clel_pkg::ST_FIN2;
            end

            clel_pkg::ST_FIN2:
            begin
                v_ra = head_reg;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.entry_count = clel_pkg::ENTRY_W'(count_reg);
                    rsp_next.head_value  = (count_reg == '0) ? '0
                                           : clel_pkg::from_val(v_rd);
                    rsp_valid_next       = 1'b1;
                    state_next           = clel_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = clel_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clel_pkg::ST_INIT;
            rsp_valid_reg <= 1'b0;
            init_reg      <= '0;
            head_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            init_reg      <= init_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rsp_reg    <= rsp_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        p_reg      <= p_next;
        new_reg    <= new_next;
        walk_reg   <= walk_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(clel_pkg::CAPACITY))
        else $error("node count above capacity");

    a_elim_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clel_pkg::ST_ELIM_DIV) |-> (count_reg > CW'(1)))
        else $error("remainder run with fewer than two nodes");

    a_cmd_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg == clel_pkg::ST_DECODE))
        else $error("accepted command not decoded");

    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clel_pkg::ST_FIN2 && state_next == clel_pkg::ST_IDLE)
        |=> rsp_valid_reg)
        else $error("result not loaded at command end");
`endif

endmodule

[sv/clel_ram.sv]
// ----------------------------------------------------------------------------
// clel_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module clel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/clel_rem.sv]
// ----------------------------------------------------------------------------
// clel_rem
// Bit-serial remainder of the skip count by the node count, one bit a cycle.
// ----------------------------------------------------------------------------
module clel_rem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [clel_pkg::SKIP_W-1:0] dividend,
    input  logic [clel_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [clel_pkg::CNT_W-1:0] remainder
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [clel_pkg::SKIP_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [clel_pkg::SKIP_W-1:0]       dvd_reg, dvd_next;
    logic [clel_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [clel_pkg::CNT_W:0]          trial;
    logic [clel_pkg::CNT_W:0]          diff;

    // restoring step: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        trial        = {rem_reg, dvd_reg[clel_pkg::SKIP_W-1]};
        diff         = trial - {1'b0, divisor};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = clel_pkg::SKIP_CNT_W'(clel_pkg::SKIP_W - 1);
            dvd_next     = dividend;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[clel_pkg::SKIP_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? diff[clel_pkg::CNT_W-1:0]
                                                  : trial[clel_pkg::CNT_W-1:0];
            if (bit_cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[dv/tb_circular_list_engine.sv]
// ----------------------------------------------------------------------------
// tb_circular_list_engine
// Self-checking bench for the circular list engine: a behavioral list model
// predicts status, count and head value of every command; results are checked
// in order under random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_circular_list_engine;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    clel_pkg::cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    clel_pkg::rsp_t rsp;

    circular_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // List model: values kept in order from the head
    logic signed [31:0] list_vals[$];
    clel_pkg::rsp_t pending_rsps[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int errors;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    // Index of first match from the head, or -1
    function automatic int find_pos(input logic signed [31:0] key);
        foreach (list_vals[i])
        begin
            if (list_vals[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Apply one command to the list model and build the expected result
    function automatic clel_pkg::rsp_t list_apply(input clel_pkg::cmd_t c);
        clel_pkg::rsp_t r;
        int pos;
        int cur;
        int steps;
        r.status = clel_pkg::STAT_OK;
        if (c.mode == clel_pkg::MODE_PUSH_FRONT || c.mode == clel_pkg::MODE_PUSH_BACK)
        begin
            if (list_vals.size() >= clel_pkg::CAPACITY)
                r.status = clel_pkg::STAT_FULL;
            else if (c.mode == clel_pkg::MODE_PUSH_FRONT)
                list_vals.push_front(c.search_key);
            else
                list_vals.push_back(c.search_key);
        end
        else if (c.mode <= clel_pkg::MODE_ELIMINATE)
        begin
            if (list_vals.size() == 0)
                r.status = clel_pkg::STAT_EMPTY;
            else if (c.mode == clel_pkg::MODE_POP_FRONT)
                void'(list_vals.pop_front());
            else if (c.mode == clel_pkg::MODE_POP_BACK)
                void'(list_vals.pop_back());
            else if (c.mode == clel_pkg::MODE_FIND)
                r.status = (find_pos(c.search_key) < 0) ? clel_pkg::STAT_NOT_FOUND
                                                        : clel_pkg::STAT_OK;
            else if (c.mode == clel_pkg::MODE_INS_BEFORE ||
                     c.mode == clel_pkg::MODE_INS_AFTER)
            begin
                pos = find_pos(c.search_key);
                if (pos < 0)
                    r.status = clel_pkg::STAT_NOT_FOUND;
                else if (list_vals.size() >= clel_pkg::CAPACITY)
                    r.status = clel_pkg::STAT_FULL;
                else if (c.mode == clel_pkg::MODE_INS_BEFORE)
                    list_vals.insert(pos, c.new_value);
                else
                    list_vals.insert(pos + 1, c.new_value);
            end
            else if (c.mode == clel_pkg::MODE_REMOVE)
            begin
                pos = find_pos(c.search_key);
                if (pos < 0)
                    r.status = clel_pkg::STAT_NOT_FOUND;
                else
                    list_vals.delete(pos);
            end
            else
            begin
                // Elimination: survivor becomes the head
                cur = 0;
                while (list_vals.size() > 1)
                begin
                    steps = c.skip_count % list_vals.size();
                    cur = (cur + steps) % list_vals.size();
                    list_vals.delete(cur);
                    if (cur >= list_vals.size())
                        cur = 0;
                end
                cur = 0;
            end
        end
        r.entry_count = clel_pkg::ENTRY_W'(list_vals.size());
        r.head_value = (list_vals.size() > 0) ? list_vals[0] : 32'sd0;
        return r;
    endfunction

    // Send one command and record its expected result
    task automatic send_cmd(input logic [3:0] m, input logic signed [31:0] key,
                            input logic signed [31:0] val, input logic [15:0] skip);
        clel_pkg::cmd_t c;
        c.mode = m;
        c.search_key = key;
        c.new_value = val;
        c.skip_count = skip;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_rsps.push_back(list_apply(c));
    endtask

    // Receiver stall: random idling plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        clel_pkg::rsp_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, rsp);
                errors++;
            end
            else
            begin
                exp_r = pending_rsps.pop_front();
                if (rsp.status !== exp_r.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                             rsp.status);
                    errors++;
                end
                if (rsp.entry_count !== exp_r.entry_count)
                begin
                    $display("%0t: count exp %0d got %0d", $time, exp_r.entry_count,
                             rsp.entry_count);
                    errors++;
                end
                if (rsp.head_value !== exp_r.head_value)
                begin
                    $display("%0t: head exp %0d got %0d", $time, exp_r.head_value,
                             rsp.head_value);
                    errors++;
                end
            end
        end
    end

    // Pick a key: mostly one present in the list
    function automatic logic signed [31:0] pick_key();
        if (list_vals.size() > 0 && $urandom_range(99) < 75)
            return list_vals[$urandom_range(list_vals.size() - 1)];
        return $urandom_range(15);
    endfunction

    task automatic test_directed();
        send_cmd(clel_pkg::MODE_POP_FRONT, 0, 0, 0);
        send_cmd(clel_pkg::MODE_POP_BACK, 0, 0, 0);
        send_cmd(clel_pkg::MODE_FIND, 1, 0, 0);
        send_cmd(clel_pkg::MODE_INS_BEFORE, 1, 2, 0);
        send_cmd(clel_pkg::MODE_INS_AFTER, 1, 2, 0);
        send_cmd(clel_pkg::MODE_REMOVE, 1, 0, 0);
        send_cmd(clel_pkg::MODE_ELIMINATE, 0, 0, 3);
        send_cmd(clel_pkg::MODE_PUSH_FRONT, 32'sh7fffffff, 0, 0);
        send_cmd(clel_pkg::MODE_PUSH_BACK, 32'sh80000000, 0, 16'hffff);
        send_cmd(clel_pkg::MODE_PUSH_FRONT, -1, 0, 0);
        send_cmd(clel_pkg::MODE_FIND, 32'sh80000000, 0, 0);
        send_cmd(clel_pkg::MODE_FIND, 5, 0, 0);
        send_cmd(clel_pkg::MODE_INS_BEFORE, -1, 32'sh5a5a5a5a, 0);
        send_cmd(clel_pkg::MODE_INS_AFTER, 32'sh80000000, 32'sha5a5a5a5, 0);
        send_cmd(clel_pkg::MODE_INS_BEFORE, 9, 9, 0);
        send_cmd(clel_pkg::MODE_REMOVE, 32'sh5a5a5a5a, 0, 0);
        send_cmd(clel_pkg::MODE_REMOVE, 9, 0, 0);
        send_cmd(clel_pkg::MODE_ELIMINATE, 0, 0, 0);
        send_cmd(4'd9, 0, 0, 0);
        send_cmd(4'd15, -1, -1, 16'hffff);
        send_cmd(clel_pkg::MODE_POP_BACK, 0, 0, 0);
        send_cmd(clel_pkg::MODE_POP_FRONT, 0, 0, 0);
    endtask

    // Fill to capacity and exercise the full store, then drain
    task automatic test_full_store();
        while (list_vals.size() < clel_pkg::CAPACITY)
            send_cmd(clel_pkg::MODE_PUSH_BACK, $urandom(), 0, 0);
        send_cmd(clel_pkg::MODE_PUSH_FRONT, 1, 0, 0);
        send_cmd(clel_pkg::MODE_PUSH_BACK, 1, 0, 0);
        send_cmd(clel_pkg::MODE_INS_AFTER, list_vals[100], 3, 0);
        send_cmd(clel_pkg::MODE_INS_BEFORE, 12345, 3, 0);
        send_cmd(clel_pkg::MODE_ELIMINATE, 0, 0, 16'hffff);
        send_cmd(clel_pkg::MODE_POP_FRONT, 0, 0, 0);
    endtask

    // Random commands with a bounded, small list
    task automatic test_random(input int count);
        logic [3:0] m;
        for (int i = 0; i < count; i++)
        begin
            m = $urandom_range(99) < 3 ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            if (m == clel_pkg::MODE_ELIMINATE && $urandom_range(3) != 0)
                m = clel_pkg::MODE_FIND;
            if (list_vals.size() > 40 && (m <= clel_pkg::MODE_PUSH_BACK))
                m = clel_pkg::MODE_POP_FRONT;
            send_cmd(m, (m <= clel_pkg::MODE_PUSH_BACK && $urandom_range(1)) ? $urandom()
                     : pick_key(), $urandom(),
                     $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(5)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        for (int i = 0; i < 30; i++)
            send_cmd(clel_pkg::MODE_PUSH_BACK, $urandom(), 0, 0);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 14;
        recv_idle_pct = 67;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_store();
        test_random(280);
        send_idle_pct = 67;
        recv_idle_pct = 14;
        test_backpressure();
        test_random(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(280);
        drain_results();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
